[rtl/balanced_3d_grid_factorizer_core_defines.svh]
// assertion macros shared by the grid factoriser rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef BALANCED_3D_GRID_FACTORIZER_CORE_DEFINES_SVH
`define BALANCED_3D_GRID_FACTORIZER_CORE_DEFINES_SVH

`ifndef SYNTH

// plain property, checked outside reset
`define BGF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define BGF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define BGF_ASSERT(lbl, prop, msg)
`define BGF_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

[rtl/bgf_pkg.sv]
// shared widths, command and status types for the grid factoriser
// no dependencies
package bgf_pkg;

  localparam int unsigned N_W       = 13;  // node count and grid dimensions
  localparam int unsigned R_W       = 7;   // root, i and j (floor(sqrt(8191)) = 90)
  localparam int unsigned P_W       = 14;  // i*j and squares of i, j
  localparam int unsigned KSQ_W     = 26;  // k*k
  localparam int unsigned IJSQ_W    = 15;  // i*i + j*j
  localparam int unsigned SCORE_W   = 27;  // i*i + j*j + k*k
  localparam int unsigned CNT_W     = 4;   // divider step counter
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 40;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch node count, clear best triple
    logic root_step;  // bump root counter
    logic pair_init;  // i = 1, j = 1
    logic i_next;     // i + 1, j = 1
    logic j_next;     // j + 1
    logic div_start;  // start n / (i*j)
    logic score;      // register squares
    logic cmp;        // compare score, keep if not worse
    logic finish;     // load output register
  } bgf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_input;  // zero or above the node limit
    logic root_done;  // (r+1)^2 > n
    logic p_over;     // i*j > n
    logic i_last;
    logic j_last;
    logic div_done;
    logic exact;      // remainder is zero
    logic out_free;   // output register can take a result
  } bgf_sts_t;

endpackage

[rtl/bgf_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on bgf_pkg and the core defines header
`include "balanced_3d_grid_factorizer_core_defines.svh"

module bgf_divider
  import bgf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [N_W-1:0]   dividend_i,
  input  logic [P_W-1:0]   divisor_i,
  output logic [N_W-1:0]   quotient_o,
  output logic [P_W-1:0]   remainder_o,
  output logic             done_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [P_W-1:0]   rem_q, rem_d;
  logic [P_W-1:0]   dvs_q, dvs_d;
  logic [P_W-1:0]   shifted;
  logic [P_W:0]     diff;
  logic             ge;

  assign shifted = {rem_q[P_W-2:0], quo_q[N_W-1]};
  assign diff    = {1'b0, shifted} - {1'b0, dvs_q};
  assign ge      = ~diff[P_W];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[P_W-1:0] : shifted;
      quo_d = {quo_q[N_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = busy_q && (cnt_q == '0);

  // partial remainder stays below the divisor throughout
  `BGF_ASSERT_IMPL(a_rem_below_divisor, busy_q, rem_q < dvs_q, "remainder not below divisor")

endmodule

[rtl/bgf_datapath.sv]
// datapath: root counter, pair counters, divider, score, best triple and output register
// depends on bgf_pkg, bgf_divider and the core defines header
`include "balanced_3d_grid_factorizer_core_defines.svh"

module bgf_datapath
  import bgf_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bgf_cmd_t             cmd_i,
  output bgf_sts_t             sts_o,
  input  logic [N_W-1:0]       node_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [N_W-1:0]       grid_x_o,
  output logic [N_W-1:0]       grid_y_o,
  output logic [N_W-1:0]       grid_z_o
);

  localparam int unsigned LIM_W = 17;

  logic [N_W-1:0]     n_q;
  logic [R_W-1:0]     r_q, r_d;
  logic [R_W-1:0]     i_q, i_d, j_q, j_d;
  logic [P_W-1:0]     r1_sq;
  logic [P_W-1:0]     p;
  logic [N_W-1:0]     quo;
  logic [P_W-1:0]     rem;
  logic               div_done;
  logic [KSQ_W-1:0]   ksq_q;
  logic [IJSQ_W-1:0]  ijsq_q;
  logic [SCORE_W-1:0] score, best_q;
  logic               keep;
  logic               have_best_q;
  logic [N_W-1:0]     bx_q, by_q, bz_q;
  logic               out_valid_q;
  logic [N_W-1:0]     x_q, y_q, z_q;

  // root search: counts r up while (r+1)^2 still fits
  assign r1_sq = P_W'(r_q + R_W'(1)) * P_W'(r_q + R_W'(1));
  assign p     = P_W'(i_q) * P_W'(j_q);

  always_comb begin
    r_d = r_q;
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.load)      r_d = '0;
    if (cmd_i.root_step) r_d = r_q + R_W'(1);
    if (cmd_i.pair_init) begin
      i_d = R_W'(1);
      j_d = R_W'(1);
    end
    if (cmd_i.i_next) begin
      i_d = i_q + R_W'(1);
      j_d = R_W'(1);
    end
    if (cmd_i.j_next)    j_d = j_q + R_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= node_count_i;
    end
    r_q <= r_d;
    i_q <= i_d;
    j_q <= j_d;
  end

  bgf_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (n_q),
    .divisor_i   (p),
    .quotient_o  (quo),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  // squares registered before the sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.score) begin
      ksq_q  <= KSQ_W'(quo) * KSQ_W'(quo);
      ijsq_q <= IJSQ_W'(P_W'(i_q) * P_W'(i_q)) + IJSQ_W'(P_W'(j_q) * P_W'(j_q));
    end
  end

  assign score = SCORE_W'(ksq_q) + SCORE_W'(ijsq_q);
  // ties go to the later candidate
  assign keep  = !have_best_q || (score <= best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
    end else if (cmd_i.load) begin
      have_best_q <= 1'b0;
    end else if (cmd_i.cmp && keep) begin
      have_best_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q <= '0;
      by_q <= '0;
      bz_q <= '0;
    end else if (cmd_i.cmp && keep) begin
      best_q <= score;
      bx_q   <= quo;
      by_q   <= N_W'(j_q);
      bz_q   <= N_W'(i_q);
    end
  end

  // output register, larger of k and i goes first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      x_q <= (bz_q > bx_q) ? bz_q : bx_q;
      y_q <= by_q;
      z_q <= (bz_q > bx_q) ? bx_q : bz_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign grid_x_o    = x_q;
  assign grid_y_o    = y_q;
  assign grid_z_o    = z_q;

  assign sts_o.bad_input = (n_q == '0) || (LIM_W'(n_q) > LIM_W'(MAX_NODES));
  assign sts_o.root_done = r1_sq > P_W'(n_q);
  assign sts_o.p_over    = p > P_W'(n_q);
  assign sts_o.i_last    = (i_q == r_q);
  assign sts_o.j_last    = (j_q == r_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.exact     = (rem == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // the kept triple always factors the node count exactly
  `BGF_ASSERT_IMPL(a_best_is_factor, have_best_q,
    32'(bx_q) * 32'(by_q) * 32'(bz_q) == 32'(n_q), "best triple does not factor n")

  // result ordering after the swap
  `BGF_ASSERT_IMPL(a_out_ordered, out_valid_q, z_q <= x_q, "grid_z above grid_x")

endmodule

[rtl/bgf_ctrl.sv]
// controller state machine for the grid factoriser search
// depends on bgf_pkg
module bgf_ctrl
  import bgf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bgf_sts_t sts_i,
  output bgf_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROOT  = 3'd1;
  localparam logic [2:0] ST_PAIR  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SCORE = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;

  logic [2:0] state_q, state_d;
  logic       advance;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    advance = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts_i.bad_input) begin
          state_d = ST_FINAL;
        end else if (!sts_i.root_done) begin
          cmd_o.root_step = 1'b1;
        end else begin
          cmd_o.pair_init = 1'b1;
          state_d         = ST_PAIR;
        end
      end
      ST_PAIR: begin
        // i*j beyond n: no later j can divide either
        if (sts_i.p_over) begin
          if (sts_i.i_last) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.i_next = 1'b1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (sts_i.exact) begin
          cmd_o.score = 1'b1;
          state_d     = ST_CMP;
        end else begin
          advance = 1'b1;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        advance   = 1'b1;
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (!sts_i.j_last) begin
        cmd_o.j_next = 1'b1;
        state_d      = ST_PAIR;
      end else if (!sts_i.i_last) begin
        cmd_o.i_next = 1'b1;
        state_d      = ST_PAIR;
      end else begin
        state_d = ST_FINAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

[rtl/balanced_3d_grid_factorizer_core.sv]
// Takes a node count n and returns the most cube-like factor triple of n as
// (grid_x, grid_y, grid_z), with grid_x >= grid_z. One request is worked on at
// a time: after acceptance, floor(sqrt(n)) is found by counting up, then
// every pair (i, j) up to floor(sqrt(n)) with i*j <= n is tested by a
// one-bit-per-cycle divider; pairs with i*j > n end the inner loop. A zero
// count or one above MAX_NODES gives an all-zero result. The finished result
// sits in an output register, so a new request is taken while it waits.
//
// top level of the grid factoriser
// depends on bgf_pkg, bgf_ctrl, bgf_datapath and bgf_divider
module balanced_3d_grid_factorizer_core
  import bgf_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [12:0] node_count, [15:13] zero
  // result side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [12:0] grid_x, [25:13] grid_y,
                                               // [38:26] grid_z, [39] zero
);

  bgf_cmd_t       cmd;
  bgf_sts_t       sts;
  logic [N_W-1:0] grid_x, grid_y, grid_z;

  // sequencing: root search, pair loop, compare, hand-over to output register
  bgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, divider, squares, best triple and output register
  bgf_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_count_i (s_axis_tdata[N_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .grid_x_o     (grid_x),
    .grid_y_o     (grid_y),
    .grid_z_o     (grid_z)
  );

  // pack fields lowest first, pad to whole bytes
  assign m_axis_tdata = {1'b0, grid_z, grid_y, grid_x};

endmodule

[test/bgf_grid_checker.sv]
`timescale 1ns / 100ps
// scoreboard for the grid factoriser: works out each request's factor triple
// and compares it with the result stream; depends on bgf_pkg only
module bgf_grid_checker
  import bgf_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [12:0] node_count, [15:13] zero
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,   // [12:0] grid_x, [25:13] grid_y,
                                                 // [38:26] grid_z, [39] zero
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [N_W-1:0] x;
    logic [N_W-1:0] y;
    logic [N_W-1:0] z;
  } grid_t;

  typedef struct packed {
    logic [N_W-1:0] node;
    grid_t          grid;
  } grid_req_t;

  grid_req_t expected_grids[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // most cube-like triple, later candidate wins a tie, x and z swapped if z > x
  function automatic grid_t cube_grid_of(logic [N_W-1:0] n);
    longint unsigned best;
    longint unsigned score;
    longint unsigned prod;
    longint unsigned k;
    int unsigned     root;
    int unsigned     i;
    int unsigned     j;
    logic [N_W-1:0]  tmp;
    grid_t           g;
    g = '0;
    if (n == 0 || n > MAX_NODES) return g;
    root = 0;
    while ((root + 1) * (root + 1) <= n) root++;
    best = 3 * longint'(n) * longint'(n);
    for (i = 1; i <= root; i++) begin
      for (j = 1; j <= root; j++) begin
        prod = i * j;
        if (n % prod != 0) continue;
        k     = n / prod;
        score = i * i + j * j + k * k;
        if (score <= best) begin
          best = score;
          g.x  = k[N_W-1:0];
          g.y  = j[N_W-1:0];
          g.z  = i[N_W-1:0];
        end
      end
    end
    if (g.z > g.x) begin
      tmp = g.x;
      g.x = g.z;
      g.z = tmp;
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int unsigned node, int unsigned want,
                                 int unsigned got);
    $display("[%0t] mismatch: %s, node_count %0d, expected %0d, got %0d",
             $realtime, what, node, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin : watch
    grid_t     got;
    grid_req_t head;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.x = m_axis_tdata_i[N_W-1:0];
        got.y = m_axis_tdata_i[2*N_W-1:N_W];
        got.z = m_axis_tdata_i[3*N_W-1:2*N_W];
        if (expected_grids.size() == 0) begin
          report_mismatch("result with no request waiting, grid_x", 0, 0, got.x);
        end else begin
          head = expected_grids.pop_front();
          if (got.x != head.grid.x) report_mismatch("grid_x", head.node, head.grid.x, got.x);
          if (got.y != head.grid.y) report_mismatch("grid_y", head.node, head.grid.y, got.y);
          if (got.z != head.grid.z) report_mismatch("grid_z", head.node, head.grid.z, got.z);
        end
      end
      // a result can never belong to a request taken on the same edge
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        head.node = s_axis_tdata_i[N_W-1:0];
        head.grid = cube_grid_of(s_axis_tdata_i[N_W-1:0]);
        expected_grids.push_back(head);
      end
      pending_o = expected_grids.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// top of the grid factoriser testbench: clock, reset, request and result drivers
// depends on bgf_pkg, balanced_3d_grid_factorizer_core and bgf_grid_checker
module tb
  import bgf_pkg::*;
();

  localparam int unsigned MAX_NODES    = 4096;
  localparam int unsigned RAND_ITEMS   = 68;
  localparam int unsigned N_DIRECTED   = 25;
  localparam int unsigned N_PRESSURE   = 8;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam int unsigned LIMIT_CYCLES = 4000000;
  localparam int          IDLE_PCT     = 72;
  localparam int          BOTH_PCT     = 27;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;  // bumped by the stimulus to ask for a long hold-off
  int          hold_taken    = 0;
  int          hold_left     = 0;
  int unsigned cycle_count;

  // corners, perfect cubes and squares, primes, and the error marks
  int unsigned directed_counts [N_DIRECTED] = '{
    1, 2, 3, 4, 6, 8, 12, 16, 24, 27, 36, 48, 64, 97, 100, 128, 210, 720,
    0, 4097, 8191, 5461, 1000, 4095, 4096
  };

  idle_phase_e phase_order [4] = '{PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL,
                                   PH_BOTH_IDLE};

  always #6 clk_i = ~clk_i;

  balanced_3d_grid_factorizer_core #(
    .MAX_NODES(MAX_NODES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bgf_grid_checker #(
    .MAX_NODES(MAX_NODES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side: random stalls, or a long counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one request, idling first at the current rate; returns at a falling edge
  task automatic send_count(input int unsigned n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(n[N_W-1:0]);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // sender pauses until every outstanding result has come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly small counts so the serial search stays short; a few mid-size and
  // out-of-range ones keep the upper bits and the error path busy
  function automatic int unsigned random_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 0;
    if (roll < 9) return $urandom_range(MAX_NODES + 1, (1 << N_W) - 1);
    if (roll < 14) return $urandom_range(301, 900);
    return $urandom_range(1, 300);
  endfunction

  initial begin : stimulus
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed requests, no idling
    foreach (directed_counts[d]) send_count(directed_counts[d]);
    wait_all_results();

    // hold the result side off while tiny requests keep coming: the output
    // register fills, then the request side has to stall
    hold_req++;
    for (int p = 0; p < N_PRESSURE; p++) send_count($urandom_range(1, 16));
    wait_all_results();

    // random requests across the idling phases
    foreach (phase_order[ph]) begin
      case (phase_order[ph])
        PH_STEADY: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        PH_SENDER_IDLE: begin
          send_idle_pct = IDLE_PCT;
          stall_pct     = 0;
        end
        PH_RECEIVER_STALL: begin
          send_idle_pct = 0;
          stall_pct     = IDLE_PCT;
        end
        default: begin
          send_idle_pct = BOTH_PCT;
          stall_pct     = BOTH_PCT;
        end
      endcase
      for (int r = 0; r < RAND_ITEMS / 4; r++) send_count(random_count());
      wait_all_results();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog on a cycle counter
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

endmodule
